### design/height_gradient_colormap_core_assert.svh
// assertion macros shared by the checker of the height colour map core
// depends on nothing; taken in by `include where assertions are written
`ifndef HEIGHT_GRADIENT_COLORMAP_CORE_ASSERT_SVH
`define HEIGHT_GRADIENT_COLORMAP_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is asserted
`define HGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked assertion that also holds through reset
`define HGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/hgc_pkg.sv
// constants and default gradient for the height colour map core
// depends on nothing; used by height_gradient_colormap_core
`timescale 1ns / 1ps

package hgc_pkg;

    // number of colour stops in use, 2 .. 8
    localparam int NUM_STOPS = 8;
    // stop registers present in the register file
    localparam int STOP_REGS = 8;
    localparam int IDX_W     = 3;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    // colour channels per pixel, red first
    localparam int NCH       = 3;
    localparam int SAMPLE_W  = 32;
    // fraction and clamped sample in Q16, one included
    localparam int FRAC_W    = 17;
    // scaled sample keeps a full stop index above the fraction
    localparam int SEG_W     = FRAC_W + IDX_W;
    localparam int PROD_W    = CHAN_W + FRAC_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

    // default gradient, red<<16 | green<<8 | blue
    localparam logic [COLOR_W-1:0] STOP_RESET [STOP_REGS] = '{
        24'h0A2D6E, 24'h195AB4, 24'hE6D2A0, 24'h64B45A,
        24'h8CA064, 24'h786E64, 24'hC8C8C8, 24'hF0F0F0
    };

endpackage

### design/height_gradient_colormap_core.sv
// height colour map core: height sample in, interpolated rgb pixel out
// depends on hgc_pkg
`timescale 1ns / 1ps
//
// Input channel: i_in_valid / o_in_stall with i_height_sample, signed Q15.16.
// Output channel: o_out_valid / i_out_stall with o_red_out, o_green_out,
// o_blue_out. A transaction completes at a rising edge with valid high and
// stall low.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one colour stop per
// clock; write only while no transaction is in flight.
// Five register stages lie between an input transaction and result valid:
// clamp, segment scale, stop select, channel multiply, sum and output.
// Throughput: one pixel per clock unless the output stalls; each stage
// holds one item; the 8x17 multipliers of stage four are fully pipelined.
// Stalling: each stage moves on when it is empty or the stage after it
// moves, so bubbles close up; a stalled output holds its pixel and the
// stages behind it fill, then o_in_stall rises.
// Reset (synchronous, active low): all stages empty, stop registers take
// the default gradient.
//
module height_gradient_colormap_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [hgc_pkg::SAMPLE_W-1:0]  i_height_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic        [hgc_pkg::CHAN_W-1:0]    o_red_out,
    output logic        [hgc_pkg::CHAN_W-1:0]    o_green_out,
    output logic        [hgc_pkg::CHAN_W-1:0]    o_blue_out,
    input  logic                                 i_cfg_we,
    input  logic        [hgc_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic        [hgc_pkg::COLOR_W-1:0]   i_cfg_data
);

    // stop registers
    logic [hgc_pkg::COLOR_W-1:0] r_stop [hgc_pkg::STOP_REGS];

    // stage valid bits and enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    // stage payloads
    logic [hgc_pkg::FRAC_W-1:0]  r_t;
    logic [hgc_pkg::IDX_W-1:0]   r_idx;
    logic [hgc_pkg::FRAC_W-1:0]  r_frac2;
    logic [hgc_pkg::COLOR_W-1:0] r_a;
    logic [hgc_pkg::COLOR_W-1:0] r_b;
    logic [hgc_pkg::FRAC_W-1:0]  r_frac3;
    logic [hgc_pkg::PROD_W-1:0]  r_plo [hgc_pkg::NCH];
    logic [hgc_pkg::PROD_W-1:0]  r_phi [hgc_pkg::NCH];
    logic [hgc_pkg::CHAN_W-1:0]  r_chan [hgc_pkg::NCH];

    // next values
    logic [hgc_pkg::FRAC_W-1:0]  n_t;
    logic [hgc_pkg::SEG_W-1:0]   w_seg;
    logic [hgc_pkg::IDX_W-1:0]   n_idx;
    logic [hgc_pkg::FRAC_W-1:0]  n_frac2;
    logic [2*hgc_pkg::COLOR_W-1:0] w_pair [hgc_pkg::STOP_REGS-1];
    logic [2*hgc_pkg::COLOR_W-1:0] w_sel;
    logic [hgc_pkg::FRAC_W-1:0]  w_inv;

    // bubble-collapsing enables, output end first
    assign w_en5 = !r_v5 || !i_out_stall;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_in_stall = !w_en1;

    // clamp sample to [0, one]
    always_comb begin
        if (i_height_sample[hgc_pkg::SAMPLE_W-1]) begin
            n_t = '0;
        end else if (i_height_sample[hgc_pkg::SAMPLE_W-2:0] >
                     (hgc_pkg::SAMPLE_W-1)'(hgc_pkg::Q16_ONE)) begin
            n_t = hgc_pkg::Q16_ONE;
        end else begin
            n_t = i_height_sample[hgc_pkg::FRAC_W-1:0];
        end
    end

    // scale by segments, split into stop index and fraction, fix top end
    always_comb begin
        w_seg = hgc_pkg::SEG_W'(r_t) * hgc_pkg::SEG_W'(hgc_pkg::NUM_STOPS - 1);
        if (w_seg[hgc_pkg::SEG_W-1:16] >=
            (hgc_pkg::SEG_W-16)'(hgc_pkg::NUM_STOPS - 1)) begin
            n_idx   = hgc_pkg::IDX_W'(hgc_pkg::NUM_STOPS - 2);
            n_frac2 = hgc_pkg::Q16_ONE;
        end else begin
            n_idx   = w_seg[16 +: hgc_pkg::IDX_W];
            n_frac2 = {1'b0, w_seg[15:0]};
        end
    end

    // neighbouring stop pairs, read at one address
    always_comb begin
        for (int j = 0; j < hgc_pkg::STOP_REGS - 1; j++) begin
            w_pair[j] = {r_stop[j+1], r_stop[j]};
        end
        w_sel = w_pair[r_idx];
    end

    assign w_inv = hgc_pkg::Q16_ONE - r_frac3;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // colour stop register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hgc_pkg::STOP_REGS; k++) begin
                r_stop[k] <= hgc_pkg::STOP_RESET[k];
            end
        end else if (i_cfg_we) begin
            r_stop[i_cfg_idx] <= i_cfg_data;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_t <= n_t;
        end
        if (w_en2) begin
            r_idx   <= n_idx;
            r_frac2 <= n_frac2;
        end
        if (w_en3) begin
            r_a     <= w_sel[hgc_pkg::COLOR_W-1:0];
            r_b     <= w_sel[2*hgc_pkg::COLOR_W-1:hgc_pkg::COLOR_W];
            r_frac3 <= r_frac2;
        end
        // per channel weights, channel 0 is red
        if (w_en4) begin
            for (int c = 0; c < hgc_pkg::NCH; c++) begin
                r_plo[c] <= hgc_pkg::PROD_W'(
                                r_a[(hgc_pkg::NCH-1-c)*hgc_pkg::CHAN_W +: hgc_pkg::CHAN_W])
                            * hgc_pkg::PROD_W'(w_inv);
                r_phi[c] <= hgc_pkg::PROD_W'(
                                r_b[(hgc_pkg::NCH-1-c)*hgc_pkg::CHAN_W +: hgc_pkg::CHAN_W])
                            * hgc_pkg::PROD_W'(r_frac3);
            end
        end
        // sum and drop the fraction
        if (w_en5) begin
            for (int c = 0; c < hgc_pkg::NCH; c++) begin
                r_chan[c] <= hgc_pkg::CHAN_W'((hgc_pkg::SUM_W'(r_plo[c])
                                               + hgc_pkg::SUM_W'(r_phi[c])) >> 16);
            end
        end
    end

    assign o_out_valid = r_v5;
    assign o_red_out   = r_chan[0];
    assign o_green_out = r_chan[1];
    assign o_blue_out  = r_chan[2];

endmodule

### design/hgc_checker.sv
// port-level checker for the height colour map core, bound to the top level
// depends on hgc_pkg and height_gradient_colormap_core_assert.svh
`timescale 1ns / 1ps
`include "height_gradient_colormap_core_assert.svh"

module hgc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [hgc_pkg::CHAN_W-1:0]    o_red_out,
    input logic [hgc_pkg::CHAN_W-1:0]    o_green_out,
    input logic [hgc_pkg::CHAN_W-1:0]    o_blue_out
);

    // a stalled pixel stays and holds its value
    `HGC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out)), "stalled pixel changed")

    // pipeline empties at reset
    `HGC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // input only stalls when the output end is blocked
    `HGC_ASSERT(a_no_false_stall, i_clk, i_rst_n, (!o_out_valid || !i_out_stall) |-> !o_in_stall, "input stalled with output free")

    // a taken sample comes out as a valid pixel when the receiver keeps taking
    `HGC_ASSERT(a_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall && !i_out_stall) ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid, "pixel late")

endmodule

bind height_gradient_colormap_core hgc_checker u_hgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
